// ===== rtl/gdad_pkg.sv =====
// Shared types, constants and calendar helpers for the date-add unit.
// No dependencies; used by gdad_alu and gregorian_date_add_days_unit.
package gdad_pkg;

  localparam int unsigned OPW = 16;              // shared adder width

  localparam logic [13:0] YEAR_CAP = 14'd9999;
  localparam logic [15:0] QUAD_CENT = 16'd400;   // leap cycle length in years
  localparam logic [8:0]  QUAD_LAST = 9'd399;
  localparam logic [8:0]  YEAR_SHORT = 9'd365;
  localparam logic [8:0]  YEAR_LONG = 9'd366;
  localparam logic [3:0]  MON_FEB = 4'd2;
  localparam logic [3:0]  MON_JAN = 4'd1;
  localparam logic [3:0]  MON_DEC = 4'd12;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;
    alu_op_t        op;
  } alu_req_t;

  typedef struct packed {
    logic [OPW-1:0] res;
    logic           cout;   // carry on add, borrow on subtract
    logic           zero;
  } alu_rsp_t;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Leap test from year mod 400 and the two low bits of the year.
  function automatic logic is_leap(input logic [8:0] ymod, input logic [1:0] ylow);
    logic cent;
    cent = (ymod == 9'd0) || (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
    return ((ylow == 2'b00) && !cent) || (ymod == 9'd0);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd0;
    if (m >= MON_JAN && m <= MON_DEC) begin
      if (m == MON_FEB) begin
        len = leap ? 5'd29 : 5'd28;
      end else begin
        len = MONTH_LEN[m - MON_JAN];
      end
    end
    return len;
  endfunction

endpackage

// ===== rtl/gregorian_date_add_days_unit.sv =====
// Gregorian date plus a day count, one request at a time on a shared adder.
// After accept it reduces the start year modulo 400, adds the months before the start
// month, strips whole years, then walks the months of the last year to the result.
// in_tready is low from accept until the result is taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_tvalid.
// Depends on gdad_pkg and gdad_alu.
module gregorian_date_add_days_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // start_day[4:0], start_month[8:5], start_year[22:9],
                                  // days_to_add[37:23], zero pad [39:38]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // result_day[4:0], result_month[8:5], result_year[22:9],
                                  // zero pad [23]
  output logic [0:0]  out_tuser   // year_overflow[0]
);

  // One-hot sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,  // reduce start year modulo 400
    S_PRE   = 6'b000100,  // add lengths of months before the start month
    S_YEAR  = 6'b001000,  // strip whole years from the remainder
    S_MONTH = 6'b010000,  // strip months within the final year
    S_DONE  = 6'b100000   // hold the result until taken
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] rem_r, rem_nxt;      // running day remainder
  logic [14:0] year_r, year_nxt;    // may run past the 14-bit field before clamping
  logic [13:0] ymod_r, ymod_nxt;    // year mod 400 once S_MOD is done
  logic [3:0]  mon_r, mon_nxt;      // clamped start month
  logic [3:0]  m_r, m_nxt;          // month cursor
  logic [2:0]  step_r, step_nxt;    // shift of 400 during the reduction

  logic [4:0]  res_day_r, res_day_nxt;
  logic [3:0]  res_mon_r, res_mon_nxt;
  logic [13:0] res_year_r, res_year_nxt;
  logic        res_ovf_r, res_ovf_nxt;

  gdad_pkg::alu_req_t alu_req;
  gdad_pkg::alu_rsp_t alu_rsp;

  logic       leap;
  logic [4:0] mlen;
  logic [8:0] ylen;
  logic       in_fire;
  logic       rem_gt;      // remainder strictly above the subtrahend
  logic [3:0] in_mon;
  logic [8:0] ymod_inc;

  assign in_fire  = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign leap     = gdad_pkg::is_leap(ymod_r[8:0], year_r[1:0]);
  assign mlen     = gdad_pkg::month_days(m_r, leap);
  assign ylen     = leap ? gdad_pkg::YEAR_LONG : gdad_pkg::YEAR_SHORT;
  assign rem_gt   = !alu_rsp.cout && !alu_rsp.zero;
  assign ymod_inc = (ymod_r[8:0] == gdad_pkg::QUAD_LAST) ? 9'd0 : ymod_r[8:0] + 9'd1;

  // Clamp an out-of-range month into January..December
  always_comb begin
    in_mon = in_tdata[8:5];
    if (in_mon < gdad_pkg::MON_JAN) begin
      in_mon = gdad_pkg::MON_JAN;
    end else if (in_mon > gdad_pkg::MON_DEC) begin
      in_mon = gdad_pkg::MON_DEC;
    end
  end

  // Operand selection for the shared adder
  always_comb begin
    alu_req.a  = rem_r;
    alu_req.b  = {11'd0, mlen};
    alu_req.op = gdad_pkg::ALU_SUB;
    unique case (state_r)
      S_IDLE: begin
        // seed the remainder with day plus count
        alu_req.a  = {11'd0, in_tdata[4:0]};
        alu_req.b  = {1'b0, in_tdata[37:23]};
        alu_req.op = gdad_pkg::ALU_ADD;
      end
      S_MOD: begin
        alu_req.a = {2'd0, ymod_r};
        alu_req.b = gdad_pkg::QUAD_CENT << step_r;
      end
      S_PRE: begin
        alu_req.op = gdad_pkg::ALU_ADD;
      end
      S_YEAR: begin
        alu_req.b = {7'd0, ylen};
      end
      default: begin
      end
    endcase
  end

  gdad_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    state_nxt    = state_r;
    rem_nxt      = rem_r;
    year_nxt     = year_r;
    ymod_nxt     = ymod_r;
    mon_nxt      = mon_r;
    m_nxt        = m_r;
    step_nxt     = step_r;
    res_day_nxt  = res_day_r;
    res_mon_nxt  = res_mon_r;
    res_year_nxt = res_year_r;
    res_ovf_nxt  = res_ovf_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // Take day plus count from the shared adder
          rem_nxt   = alu_rsp.res;
          year_nxt  = {1'b0, in_tdata[22:9]};
          ymod_nxt  = in_tdata[22:9];
          mon_nxt   = in_mon;
          m_nxt     = gdad_pkg::MON_JAN;
          step_nxt  = 3'd5;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        // Restoring reduction: drop 400 << step where it fits
        if (!alu_rsp.cout) begin
          ymod_nxt = alu_rsp.res[13:0];
        end
        step_nxt = step_r - 3'd1;
        if (step_r == 3'd0) begin
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        if (m_r == mon_r) begin
          m_nxt     = gdad_pkg::MON_JAN;
          state_nxt = S_YEAR;
        end else begin
          rem_nxt = alu_rsp.res;
          m_nxt   = m_r + 4'd1;
        end
      end
      S_YEAR: begin
        // Remainder beyond a whole year: skip all twelve months at once
        if (rem_gt) begin
          rem_nxt  = alu_rsp.res;
          year_nxt = year_r + 15'd1;
          ymod_nxt = {5'd0, ymod_inc};
        end else begin
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (rem_gt) begin
          rem_nxt = alu_rsp.res;
          if (m_r == gdad_pkg::MON_DEC) begin
            m_nxt    = gdad_pkg::MON_JAN;
            year_nxt = year_r + 15'd1;
            ymod_nxt = {5'd0, ymod_inc};
          end else begin
            m_nxt = m_r + 4'd1;
          end
        end else begin
          res_day_nxt = rem_r[4:0];
          res_mon_nxt = m_r;
          if (year_r > {1'b0, gdad_pkg::YEAR_CAP}) begin
            res_year_nxt = gdad_pkg::YEAR_CAP;
            res_ovf_nxt  = 1'b1;
          end else begin
            res_year_nxt = year_r[13:0];
            res_ovf_nxt  = 1'b0;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    year_r     <= year_nxt;
    ymod_r     <= ymod_nxt;
    mon_r      <= mon_nxt;
    m_r        <= m_nxt;
    step_r     <= step_nxt;
    res_day_r  <= res_day_nxt;
    res_mon_r  <= res_mon_nxt;
    res_year_r <= res_year_nxt;
    res_ovf_r  <= res_ovf_nxt;
  end

  assign out_tvalid = (state_r == S_DONE);
  assign out_tdata  = {1'b0, res_year_r, res_mon_r, res_day_r};
  assign out_tuser  = res_ovf_r;

endmodule

// ===== rtl/gdad_alu.sv =====
// Shared add/subtract unit of the date-add sequencer.
// Depends on gdad_pkg for the request and response types.
module gdad_alu (
  input  gdad_pkg::alu_req_t req,
  output gdad_pkg::alu_rsp_t rsp
);

  logic [gdad_pkg::OPW:0] wide;

  always_comb begin
    if (req.op == gdad_pkg::ALU_SUB) begin
      wide = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      wide = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.res  = wide[gdad_pkg::OPW-1:0];
    rsp.cout = wide[gdad_pkg::OPW];
    rsp.zero = (wide[gdad_pkg::OPW-1:0] == '0);
  end

endmodule

// ===== bench/gregorian_date_add_days_unit_test.sv =====
// Self-checking bench for gregorian_date_add_days_unit: directed and random date requests,
// each result checked against a calendar predictor held in this file.
// Needs only the RTL (gdad_pkg, gdad_alu, gregorian_date_add_days_unit).
`timescale 1ns / 1ps

module gregorian_date_add_days_unit_test;

  localparam int unsigned YEAR_TOP    = 9999;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_WAIT  = 150;   // extra wait after the last result is checked
  localparam int unsigned IDLE_PCT    = 22;

  // One result as the block presents it
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        ovf;
  } date_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;

  date_out_t   pending_dates[$];   // predicted results, oldest first
  bit          steady = 1'b0;      // no idling on either side while set
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned overflows_seen = 0;
  int unsigned bad_results = 0;
  int unsigned cycle_count = 0;

  gregorian_date_add_days_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  function automatic bit leap_year(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Length of month mon in year yr; zero outside January..December
  function automatic int unsigned month_length(input int unsigned mon, input int unsigned yr);
    case (mon)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(yr) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Date that lies n days after d/mo/y. Form the day of the year, add the count, then
  // walk forward from January a month at a time, rolling the year after December.
  function automatic date_out_t date_after(input logic [4:0] d, input logic [3:0] mo,
                                           input logic [13:0] y, input logic [14:0] n);
    int unsigned rem;
    int unsigned mon;
    int unsigned yr;
    int unsigned walk;
    date_out_t   r;
    mon = mo;
    yr  = y;
    // clamp the month into January..December
    if (mon < 1) mon = 1;
    if (mon > 12) mon = 12;
    rem = d;
    for (walk = 1; walk < mon; walk++) rem += month_length(walk, yr);
    rem += n;
    walk = 1;
    while (rem > month_length(walk, yr)) begin
      rem -= month_length(walk, yr);
      walk++;
      if (walk == 13) begin
        walk = 1;
        yr++;
      end
    end
    r.day   = rem[4:0];
    r.month = walk[3:0];
    r.ovf   = (yr > YEAR_TOP);
    // clamp the year and flag it once past the top of the range
    if (r.ovf) yr = YEAR_TOP;
    r.year  = yr[13:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Present one request and hold it until the block takes it. Returns at the accepting
  // edge without touching in_tvalid, so a back-to-back request keeps it high.
  task automatic send_request(input logic [4:0] d, input logic [3:0] mo,
                              input logic [13:0] y, input logic [14:0] n);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      // mix short gaps with long ones so that the next request lands on every
      // phase of the block's month walk, not only while it is still busy
      if ($urandom_range(1)) repeat ($urandom_range(1, 4)) @(posedge clk);
      else repeat ($urandom_range(5, 120)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, n, y, mo, d};
    do @(posedge clk); while (!in_tready);
    // accepted at this edge: record the expected date
    pending_dates.push_back(date_after(d, mo, y, n));
    requests_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the scoreboard
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    date_out_t want;
    date_out_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.day   = out_tdata[4:0];
      got.month = out_tdata[8:5];
      got.year  = out_tdata[22:9];
      got.ovf   = out_tuser[0];
      results_seen++;
      if (got.ovf) overflows_seen++;
      if (pending_dates.size() == 0) begin
        bad_results++;
        $display("%0t: result with nothing outstanding: day %0d month %0d year %0d ovf %0d",
                 $time, got.day, got.month, got.year, got.ovf);
      end else begin
        want = pending_dates.pop_front();
        if (want != got) begin
          bad_results++;
          // report each failing field
          if (want.day != got.day)
            $display("%0t: result_day expected %0d actual %0d", $time, want.day, got.day);
          if (want.month != got.month)
            $display("%0t: result_month expected %0d actual %0d", $time, want.month,
                     got.month);
          if (want.year != got.year)
            $display("%0t: result_year expected %0d actual %0d", $time, want.year,
                     got.year);
          if (want.ovf != got.ovf)
            $display("%0t: year_overflow expected %0d actual %0d", $time, want.ovf,
                     got.ovf);
        end
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d results outstanding", $time,
               pending_dates.size());
      $display("gregorian_date_add_days_unit_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and the leap-year rules on well-formed dates
  task automatic test_calendar_edges();
    send_request(5'd1, 4'd1, 14'd1, 15'd0);
    send_request(5'd31, 4'd12, 14'd9999, 15'd0);
    send_request(5'd1, 4'd1, 14'd1, 15'd32767);
    send_request(5'd1, 4'd1, 14'd9999, 15'd32767);
    send_request(5'd31, 4'd12, 14'd9998, 15'd366);
    send_request(5'd28, 4'd2, 14'd2024, 15'd1);   // divisible by four: leap
    send_request(5'd28, 4'd2, 14'd2023, 15'd1);
    send_request(5'd28, 4'd2, 14'd1900, 15'd1);   // century: not leap
    send_request(5'd28, 4'd2, 14'd2000, 15'd1);   // fourth century: leap
    send_request(5'd31, 4'd12, 14'd2023, 15'd1);
    send_request(5'd30, 4'd4, 14'd2020, 15'd1);
    send_request(5'd31, 4'd1, 14'd2020, 15'd29);
  endtask

  // Inputs outside the calendar: odd months, day zero, day past month end, year zero,
  // overflow out of range and start years already above the top
  task automatic test_odd_dates();
    send_request(5'd15, 4'd0, 14'd2021, 15'd0);   // month zero reads as January
    send_request(5'd15, 4'd13, 14'd2021, 15'd0);  // above twelve reads as December
    send_request(5'd15, 4'd15, 14'd2021, 15'd40);
    send_request(5'd0, 4'd1, 14'd2021, 15'd0);    // day zero of January
    send_request(5'd0, 4'd3, 14'd2021, 15'd0);    // day zero of March: end of February
    send_request(5'd31, 4'd2, 14'd2021, 15'd0);   // February 31 spills into March
    send_request(5'd28, 4'd2, 14'd0, 15'd1);      // year zero is leap
    send_request(5'd31, 4'd12, 14'd9999, 15'd1);  // steps past the top year
    send_request(5'd1, 4'd1, 14'd10000, 15'd5);
    send_request(5'd31, 4'd15, 14'd16383, 15'd32767);
  endtask

  // Well-formed dates with random day counts, some near the top year
  task automatic test_random_dates(input int unsigned count);
    logic [3:0]  mo;
    logic [13:0] y;
    logic [4:0]  d;
    logic [14:0] n;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      // hold both sides busy for the opening stretch
      steady = (i < 150);
      mo   = 4'($urandom_range(1, 12));
      if ($urandom_range(9) == 0) y = 14'($urandom_range(9900, 9999));
      else y = 14'($urandom_range(1, 9999));
      d    = 5'($urandom_range(1, month_length(mo, y)));
      pick = $urandom_range(99);
      if (pick < 35) n = 15'($urandom_range(0, 400));
      else if (pick < 45) n = 15'($urandom_range(0, 31));
      else n = 15'($urandom_range(0, 32767));
      send_request(d, mo, y, n);
    end
    steady = 1'b0;
  endtask

  // Every field over its full width
  task automatic test_raw_fields(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_request(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                   14'($urandom_range(0, 16383)), 15'($urandom_range(0, 32767)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_calendar_edges();
    test_odd_dates();
    test_random_dates(500);
    test_raw_fields(130);

    // drop the request line once the last request is taken
    in_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d date requests (edges, odd fields, random dates, raw fields);",
             requests_sent);
    $display("checked %0d results, %0d of them year overflows, %0d failing.",
             results_seen, overflows_seen, bad_results);
    if (bad_results == 0 && pending_dates.size() == 0) begin
      $display("gregorian_date_add_days_unit_test: PASS");
    end else begin
      $display("gregorian_date_add_days_unit_test: FAIL");
    end
    $finish;
  end

endmodule
